@@ src/spi_master_byte_engine_defines.svh @@
// Assertion macros shared by the engine modules.
// The clock and reset names are those of the module that uses the macro.
`ifndef SPI_MASTER_BYTE_ENGINE_DEFINES_SVH
`define SPI_MASTER_BYTE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define SMBE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMBE_ASSERT_IMP(label, ante, cons, msg)
`define SMBE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/smbe_pkg.sv @@
package smbe_pkg;

    localparam int FRAME_BITS_DEF      = 8;
    localparam int MAX_HALF_PERIOD_DEF = 500;

    localparam logic [8:0] DEFAULT_HALF_PERIOD = 9'd5;

    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CPOL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CPHA = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF = 2'd2;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_XCHG = 2'd2;

    // One tick after classification by the front part.
    typedef struct packed {
        logic       start;
        logic       drives;   // frame drives MOSI
        logic       receives; // frame reports a received byte
        logic [7:0] tx;
        logic       final_mark;
        logic       miso;
    } t_item;

    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done;
    } t_result;

endpackage

@@ src/smbe_front.sv @@
`include "spi_master_byte_engine_defines.svh"

module smbe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_start_req,
    input  logic [1:0]     i_operation,
    input  logic [7:0]     i_tx_byte,
    input  logic           i_final_byte,
    input  logic           i_miso_level,
    output logic           o_item_valid,
    output smbe_pkg::t_item o_item,
    input  logic           i_pop
);
    import smbe_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    t_item      item_in;

    assign o_in_ready   = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_in_valid && o_in_ready;

    // Operation three runs as an exchange.
    always_comb begin
        item_in.start      = i_start_req;
        item_in.drives     = (i_operation != OP_RECV);
        item_in.receives   = (i_operation != OP_SEND);
        item_in.tx         = i_tx_byte;
        item_in.final_mark = i_final_byte;
        item_in.miso       = i_miso_level;
    end

    always_comb begin
        n_wr_ptr = push  ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    `SMBE_ASSERT_IMP(a_no_pop_empty, i_pop, r_count != 2'd0, "pop from empty queue")
    `SMBE_ASSERT_IMP(a_count_range, 1'b1, r_count != 2'd3, "queue count out of range")
    `SMBE_ASSERT_NEXT(a_full_holds, (r_count == 2'd2) && !i_pop, r_count == 2'd2,
        "full queue lost an entry")

endmodule

@@ src/smbe_back.sv @@
`include "spi_master_byte_engine_defines.svh"

module smbe_back #(
    parameter int FRAME_BITS      = smbe_pkg::FRAME_BITS_DEF,
    parameter int MAX_HALF_PERIOD = smbe_pkg::MAX_HALF_PERIOD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smbe_pkg::t_cfg_wr i_cfg,
    input  logic              i_item_valid,
    input  smbe_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output smbe_pkg::t_result o_result
);
    import smbe_pkg::*;

    localparam int         BitCntW = $clog2(FRAME_BITS + 1);
    localparam logic [8:0] MaxHalf = 9'(MAX_HALF_PERIOD);

    logic                  r_cpol, n_cpol;
    logic                  r_cpha, n_cpha;
    logic [8:0]            r_half, n_half;

    logic [8:0]            r_tick, n_tick;
    logic [BitCntW-1:0]    r_bit, n_bit;
    logic                  r_second, n_second;
    logic [FRAME_BITS-1:0] r_out_sh, n_out_sh;
    logic [FRAME_BITS-1:0] r_in_sh, n_in_sh;
    logic                  r_active, n_active;
    logic                  r_drives, n_drives;
    logic                  r_receives, n_receives;
    logic                  r_final, n_final;
    logic                  r_clock_out, n_clock_out;
    logic                  r_data_out, n_data_out;

    logic                  r_out_valid, n_out_valid;
    t_result               r_result, n_result;

    logic                  step;
    logic [8:0]            eff_half;
    logic [8:0]            tick_inc;
    logic [BitCntW-1:0]    bit_inc;

    assign step        = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_pop       = step;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign tick_inc    = r_tick + 9'd1;
    assign bit_inc     = r_bit + BitCntW'(1);

    always_comb begin
        if (r_half == 9'd0) begin
            eff_half = 9'd1;
        end else if (r_half > MaxHalf) begin
            eff_half = MaxHalf;
        end else begin
            eff_half = r_half;
        end
    end

    always_comb begin
        n_cpol      = r_cpol;
        n_cpha      = r_cpha;
        n_half      = r_half;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_second    = r_second;
        n_out_sh    = r_out_sh;
        n_in_sh     = r_in_sh;
        n_active    = r_active;
        n_drives    = r_drives;
        n_receives  = r_receives;
        n_final     = r_final;
        n_clock_out = r_clock_out;
        n_data_out  = r_data_out;
        n_out_valid = r_out_valid;
        n_result    = r_result;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (step) begin
            n_result.rx_valid = 1'b0;
            n_result.rx_byte  = 8'd0;
            n_result.done     = 1'b0;
            if (!r_active) begin
                n_clock_out = r_cpol;
                if (i_item.start) begin
                    n_active   = 1'b1;
                    n_drives   = i_item.drives;
                    n_receives = i_item.receives;
                    n_final    = i_item.final_mark;
                    n_out_sh   = FRAME_BITS'(i_item.tx);
                    n_in_sh    = '0;
                    n_bit      = '0;
                    n_second   = 1'b0;
                    n_tick     = 9'd0;
                    if (!r_cpha && i_item.drives) begin
                        n_data_out = n_out_sh[FRAME_BITS-1];
                    end
                end
            end else begin
                n_tick = tick_inc;
                if (tick_inc >= eff_half) begin
                    n_tick      = 9'd0;
                    n_clock_out = ~r_clock_out;
                    if (!r_second) begin
                        // Leading edge.
                        n_second = 1'b1;
                        if (!r_cpha) begin
                            n_in_sh = {r_in_sh[FRAME_BITS-2:0], i_item.miso};
                        end else begin
                            if (r_drives) begin
                                n_data_out = r_out_sh[FRAME_BITS-1];
                            end
                            n_out_sh = {r_out_sh[FRAME_BITS-2:0], 1'b0};
                        end
                    end else begin
                        // Trailing edge closes one bit.
                        n_second = 1'b0;
                        if (!r_cpha) begin
                            n_out_sh = {r_out_sh[FRAME_BITS-2:0], 1'b0};
                        end else begin
                            n_in_sh = {r_in_sh[FRAME_BITS-2:0], i_item.miso};
                        end
                        n_bit = bit_inc;
                        if (bit_inc >= BitCntW'(FRAME_BITS)) begin
                            n_active    = 1'b0;
                            n_bit       = '0;
                            n_clock_out = r_cpol;
                            if (r_receives) begin
                                n_result.rx_valid = 1'b1;
                                n_result.rx_byte  = n_in_sh[7:0];
                            end
                            n_result.done = r_final;
                        end else if (!r_cpha && r_drives) begin
                            n_data_out = n_out_sh[FRAME_BITS-1];
                        end
                    end
                end
            end
            n_result.sck  = n_clock_out;
            n_result.mosi = n_data_out;
            n_result.busy = n_active;
            n_out_valid   = 1'b1;
        end

        if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_CPOL: begin
                    n_cpol = i_cfg.data[0];
                    if (!r_active) begin
                        n_clock_out = i_cfg.data[0];
                    end
                end
                CFG_CPHA: n_cpha = i_cfg.data[0];
                CFG_HALF: n_half = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpol      <= 1'b0;
            r_cpha      <= 1'b0;
            r_half      <= DEFAULT_HALF_PERIOD;
            r_tick      <= 9'd0;
            r_bit       <= '0;
            r_second    <= 1'b0;
            r_out_sh    <= '0;
            r_in_sh     <= '0;
            r_active    <= 1'b0;
            r_drives    <= 1'b1;
            r_receives  <= 1'b0;
            r_final     <= 1'b0;
            r_clock_out <= 1'b0;
            r_data_out  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cpol      <= n_cpol;
            r_cpha      <= n_cpha;
            r_half      <= n_half;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_second    <= n_second;
            r_out_sh    <= n_out_sh;
            r_in_sh     <= n_in_sh;
            r_active    <= n_active;
            r_drives    <= n_drives;
            r_receives  <= n_receives;
            r_final     <= n_final;
            r_clock_out <= n_clock_out;
            r_data_out  <= n_data_out;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    `SMBE_ASSERT_IMP(a_idle_bit_zero, !r_active, r_bit == '0, "bit counter left nonzero")
    `SMBE_ASSERT_IMP(a_rx_ends_frame, r_out_valid && r_result.rx_valid, !r_result.busy,
        "received byte reported while busy")
    `SMBE_ASSERT_IMP(a_done_ends_frame, r_out_valid && r_result.done, !r_result.busy,
        "transfer done reported while busy")
    `SMBE_ASSERT_IMP(a_rx_byte_clear, r_out_valid && !r_result.rx_valid,
        r_result.rx_byte == 8'd0, "stray received byte")

endmodule

@@ src/spi_master_byte_engine.sv @@
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      start_req operation tx_byte
//                                                    final_byte miso_level
// out       output     o_out_valid / i_out_ready    sck_level mosi_level busy_res
//                                                    rx_valid rx_byte transfer_done
// cfg       input      i_cfg_we                     i_cfg_index i_cfg_data
//
// One beat in gives one beat out; a beat is accepted every cycle while the output drains.
// A beat is registered in the two-entry front queue and then in the output register.
// Synchronous active-low reset clears the queue and the engine state and restores the default configuration.
// A stalled output holds its beat; the queue absorbs up to two more input beats.
module spi_master_byte_engine #(
    parameter int FRAME_BITS      = smbe_pkg::FRAME_BITS_DEF,
    parameter int MAX_HALF_PERIOD = smbe_pkg::MAX_HALF_PERIOD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [smbe_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [smbe_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_start_req,
    input  logic [1:0]                       i_operation,
    input  logic [7:0]                       i_tx_byte,
    input  logic                             i_final_byte,
    input  logic                             i_miso_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_sck_level,
    output logic                             o_mosi_level,
    output logic                             o_busy_res,
    output logic                             o_rx_valid,
    output logic [7:0]                       o_rx_byte,
    output logic                             o_transfer_done
);
    import smbe_pkg::*;

    t_cfg_wr cfg_wr;
    t_item   item;
    logic    item_valid;
    logic    pop;
    t_result result;

    always_comb begin
        cfg_wr.we    = i_cfg_we;
        cfg_wr.index = i_cfg_index;
        cfg_wr.data  = i_cfg_data;
    end

    smbe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_req  (i_start_req),
        .i_operation  (i_operation),
        .i_tx_byte    (i_tx_byte),
        .i_final_byte (i_final_byte),
        .i_miso_level (i_miso_level),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    smbe_back #(
        .FRAME_BITS      (FRAME_BITS),
        .MAX_HALF_PERIOD (MAX_HALF_PERIOD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_sck_level     = result.sck;
    assign o_mosi_level    = result.mosi;
    assign o_busy_res      = result.busy;
    assign o_rx_valid      = result.rx_valid;
    assign o_rx_byte       = result.rx_byte;
    assign o_transfer_done = result.done;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smbe_pkg::*;

    localparam int         STALL_LIMIT   = 1000;
    localparam int         RANDOM_TICKS  = 600;
    // Operation code 3 is not a named operation; the engine treats it as an exchange.
    localparam logic [1:0] OP_XCHG_ALIAS = 2'd3;

    typedef enum {MISO_LOW, MISO_HIGH, MISO_RAND} t_miso_src;

    // Tracks the engine's serial pins tick by tick and checks every output beat.
    class t_sck_mosi_tracker;
        bit       cpol;
        bit       cpha;
        bit [8:0] half_cfg;

        bit [8:0] div_cnt;
        bit [3:0] bits_done;
        bit       in_second;
        bit [7:0] tx_sh;
        bit [7:0] rx_sh;
        bit       running;
        bit [1:0] op_held;
        bit       fin_held;
        bit       sck_q;
        bit       mosi_q;

        t_result     pins_due[$];
        int unsigned fail_count;
        int unsigned frames_started;
        int unsigned rx_reports;
        int unsigned final_frames;

        function new();
            half_cfg = DEFAULT_HALF_PERIOD;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CPOL: begin
                    cpol = val[0];
                    if (!running)
                        sck_q = cpol;
                end
                CFG_CPHA: cpha = val[0];
                CFG_HALF: half_cfg = val;
                default: ;
            endcase
        endfunction

        function int unsigned half_ticks();
            if (half_cfg == 0)
                return 1;
            if (half_cfg > MAX_HALF_PERIOD_DEF)
                return MAX_HALF_PERIOD_DEF;
            return half_cfg;
        endfunction

        function void take_tick(bit start, bit [1:0] op, bit [7:0] tx, bit fin, bit miso);
            t_result want;
            want = '0;
            if (!running) begin
                sck_q = cpol;
                if (start) begin
                    running   = 1'b1;
                    op_held   = (op > OP_XCHG) ? OP_XCHG : op;
                    fin_held  = fin;
                    tx_sh     = tx;
                    rx_sh     = '0;
                    bits_done = '0;
                    in_second = 1'b0;
                    div_cnt   = '0;
                    if (!cpha && op_held != OP_RECV)
                        mosi_q = tx_sh[7];
                    frames_started++;
                end
            end else begin
                div_cnt = div_cnt + 1'b1;
                if (div_cnt >= half_ticks()) begin
                    div_cnt = '0;
                    sck_q   = ~sck_q;
                    if (!in_second) begin
                        in_second = 1'b1;
                        if (!cpha) begin
                            rx_sh = {rx_sh[6:0], miso};
                        end else begin
                            if (op_held != OP_RECV)
                                mosi_q = tx_sh[7];
                            tx_sh = tx_sh << 1;
                        end
                    end else begin
                        in_second = 1'b0;
                        if (!cpha)
                            tx_sh = tx_sh << 1;
                        else
                            rx_sh = {rx_sh[6:0], miso};
                        bits_done = bits_done + 1'b1;
                        if (bits_done >= FRAME_BITS_DEF) begin
                            running   = 1'b0;
                            bits_done = '0;
                            sck_q     = cpol;
                            if (op_held != OP_SEND) begin
                                want.rx_valid = 1'b1;
                                want.rx_byte  = rx_sh;
                                rx_reports++;
                            end
                            want.done = fin_held;
                            if (fin_held)
                                final_frames++;
                        end else if (!cpha && op_held != OP_RECV) begin
                            mosi_q = tx_sh[7];
                        end
                    end
                end
            end
            want.sck  = sck_q;
            want.mosi = mosi_q;
            want.busy = running;
            pins_due.push_back(want);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void match_pins(t_result got);
            t_result want;
            if (pins_due.size() == 0) begin
                $display("%0t: output beat with nothing expected, got %0h", $time, got);
                fail_count++;
                return;
            end
            want = pins_due.pop_front();
            compare_field("sck_level", want.sck, got.sck);
            compare_field("mosi_level", want.mosi, got.mosi);
            compare_field("busy_res", want.busy, got.busy);
            compare_field("rx_valid", want.rx_valid, got.rx_valid);
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("transfer_done", want.done, got.done);
        endfunction
    endclass

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic                   i_start_req  = 1'b0;
    logic [1:0]             i_operation  = '0;
    logic [7:0]             i_tx_byte    = '0;
    logic                   i_final_byte = 1'b0;
    logic                   i_miso_level = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic                   o_sck_level;
    logic                   o_mosi_level;
    logic                   o_busy_res;
    logic                   o_rx_valid;
    logic [7:0]             o_rx_byte;
    logic                   o_transfer_done;

    t_sck_mosi_tracker sb = new();
    t_result         out_beat;
    bit              gaps_on    = 1'b1;
    bit              stalls_on  = 1'b1;
    int              stall_left = 0;
    int              quiet_cycles = 0;
    int unsigned     tick_count = 0;

    spi_master_byte_engine i_dut (.*);

    always #4ns i_clk = ~i_clk;

    // Output side: check each accepted beat, then decide on the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_beat = '{sck: o_sck_level, mosi: o_mosi_level, busy: o_busy_res,
                         rx_valid: o_rx_valid, rx_byte: o_rx_byte, done: o_transfer_done};
            sb.match_pins(out_beat);
        end
        if (stall_left > 1) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left == 1) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic pick_miso(t_miso_src src);
        case (src)
            MISO_LOW:  return 1'b0;
            MISO_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic logic [1:0] pick_op();
        if ($urandom_range(0, 9) == 0)
            return OP_XCHG_ALIAS;
        return 2'($urandom_range(0, 2));
    endfunction

    // One tick of the engine; returns at the edge where the beat is accepted.
    task automatic send_tick(input logic s, input logic [1:0] op, input logic [7:0] tx,
                             input logic f, input logic m);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_req  <= s;
        i_operation  <= op;
        i_tx_byte    <= tx;
        i_final_byte <= f;
        i_miso_level <= m;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.take_tick(s, op, tx, f, m);
        tick_count++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pins_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Starts a frame and feeds ticks until it ends. Busy ticks carry random
    // start requests that must be ignored. With split_at set, polarity and
    // phase are flipped and the half period is rewritten in the middle of the frame.
    task automatic run_frame(input logic [1:0] op, input logic [7:0] tx, input logic fin,
                             input t_miso_src src, input int noise_pct, input int split_at);
        int n;
        n = 0;
        send_tick(1'b1, op, tx, fin, pick_miso(src));
        while (sb.running) begin
            n++;
            if (n == split_at) begin
                settle();
                write_cfg(CFG_CPOL, {8'($urandom), ~sb.cpol});
                write_cfg(CFG_CPHA, {8'($urandom), ~sb.cpha});
                write_cfg(CFG_HALF, 9'($urandom_range(1, 3)));
            end
            send_tick($urandom_range(0, 99) < noise_pct, 2'($urandom_range(0, 3)),
                      8'($urandom), 1'($urandom_range(0, 1)), pick_miso(src));
        end
    endtask

    initial begin
        int          nframes;
        int          r;
        int unsigned random_target;
        logic [8:0]  half_pick;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: mode 0, five ticks per half period.
        run_frame(OP_XCHG, 8'hA5, 1'b1, MISO_RAND, 0, 0);

        settle();
        write_cfg(CFG_HALF, 9'd1);
        for (int mode = 0; mode < 4; mode++) begin
            settle();
            write_cfg(CFG_CPOL, 9'(mode[1]));
            write_cfg(CFG_CPHA, 9'(mode[0]));
            run_frame(OP_SEND, 8'hFF, 1'b1, MISO_LOW, 0, 0);
            // MOSI must stay high through the receive-only frame.
            run_frame(OP_RECV, 8'h00, 1'b0, MISO_HIGH, 0, 0);
            run_frame(OP_XCHG, 8'h00, 1'b1, MISO_RAND, 100, 0);
            run_frame(OP_XCHG_ALIAS, 8'h80, 1'b0, MISO_RAND, 0, 0);
        end

        // A zero half period behaves as one tick.
        settle();
        write_cfg(CFG_HALF, 9'd0);
        run_frame(OP_XCHG, 8'h5A, 1'b1, MISO_RAND, 20, 0);

        // Polarity, phase and half period change in the middle of a frame.
        settle();
        write_cfg(CFG_HALF, 9'd3);
        run_frame(OP_XCHG, 8'hC3, 1'b1, MISO_RAND, 0, 20);
        run_frame(OP_SEND, 8'h3C, 1'b0, MISO_RAND, 0, 7);

        // A half period above the largest saturates, so the first edge comes at the
        // largest value; a short half period written after that edge ends the frame.
        settle();
        write_cfg(CFG_HALF, 9'h1FF);
        run_frame(OP_RECV, 8'h69, 1'b0, MISO_RAND, 5, MAX_HALF_PERIOD_DEF + 20);

        random_target = tick_count + RANDOM_TICKS;
        while (tick_count < random_target) begin
            settle();
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 19);
            if (r == 0)
                half_pick = '0;
            else if (r == 1)
                half_pick = 9'($urandom_range(5, 12));
            else
                half_pick = 9'($urandom_range(1, 4));
            write_cfg(CFG_CPOL, 9'($urandom));
            write_cfg(CFG_CPHA, 9'($urandom));
            write_cfg(CFG_HALF, half_pick);
            nframes = $urandom_range(2, 8);
            repeat (nframes) begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    repeat ($urandom_range(5, 20))
                        send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                  8'($urandom), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
                run_frame(pick_op(), 8'($urandom), 1'($urandom_range(0, 1)), MISO_RAND,
                          $urandom_range(0, 25), (r == 1) ? $urandom_range(2, 30) : 0);
                repeat ($urandom_range(0, 2))
                    send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end

        // Closing stretch at full rate on both sides.
        settle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_cfg(CFG_HALF, 9'd2);
        repeat (3)
            run_frame(pick_op(), 8'($urandom), 1'b1, MISO_RAND, 10, 0);

        i_in_valid <= 1'b0;
        for (int k = 0; k < STALL_LIMIT && sb.pins_due.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pins_due.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, sb.pins_due.size());
            sb.fail_count++;
        end

        $display("Ran %0d ticks with %0d frames started: %0d received bytes, %0d final frames.",
                 tick_count, sb.frames_started, sb.rx_reports, sb.final_frames);
        $display("All four SPI modes, half periods from 0 to 511, mid-frame mode changes.");
        if (sb.fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/smbe_pkg.sv
src/smbe_front.sv
src/smbe_back.sv
src/spi_master_byte_engine.sv
tb/tb_top.sv
